>>> sv/liberty_token_lexer_core_macros.svh
// Assertion helpers used by the lexer output module.
`ifndef LIBERTY_TOKEN_LEXER_CORE_MACROS_SVH
`define LIBERTY_TOKEN_LEXER_CORE_MACROS_SVH

// same-cycle implication
`define LTL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LTL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ltl_pkg.sv
package ltl_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned KindW = 5;
  localparam int unsigned ErrW  = 3;

  // token kinds
  localparam logic [KindW-1:0] K_END   = 5'd0;
  localparam logic [KindW-1:0] K_NL    = 5'd1;
  localparam logic [KindW-1:0] K_COLON = 5'd2;
  localparam logic [KindW-1:0] K_SEMI  = 5'd3;
  localparam logic [KindW-1:0] K_COMMA = 5'd4;
  localparam logic [KindW-1:0] K_PLUS  = 5'd5;
  localparam logic [KindW-1:0] K_MINUS = 5'd6;
  localparam logic [KindW-1:0] K_MULT  = 5'd7;
  localparam logic [KindW-1:0] K_DIV   = 5'd8;
  localparam logic [KindW-1:0] K_LP    = 5'd9;
  localparam logic [KindW-1:0] K_RP    = 5'd10;
  localparam logic [KindW-1:0] K_LCB   = 5'd11;
  localparam logic [KindW-1:0] K_RCB   = 5'd12;
  localparam logic [KindW-1:0] K_INT   = 5'd13;
  localparam logic [KindW-1:0] K_FLOAT = 5'd14;
  localparam logic [KindW-1:0] K_SYM   = 5'd15;
  localparam logic [KindW-1:0] K_ERR   = 5'd16;

  // error codes
  localparam logic [ErrW-1:0] E_NONE      = 3'd0;
  localparam logic [ErrW-1:0] E_BAD_CHAR  = 3'd1;
  localparam logic [ErrW-1:0] E_NO_FRAC   = 3'd2;
  localparam logic [ErrW-1:0] E_NO_EXP    = 3'd3;
  localparam logic [ErrW-1:0] E_NL_STR    = 3'd4;
  localparam logic [ErrW-1:0] E_END_STR   = 3'd5;
  localparam logic [ErrW-1:0] E_END_CMT   = 3'd6;

  // characters
  localparam logic [CharW-1:0] CH_BSL   = 8'h5C;
  localparam logic [CharW-1:0] CH_NL    = 8'h0A;
  localparam logic [CharW-1:0] CH_TAB   = 8'h09;
  localparam logic [CharW-1:0] CH_SP    = 8'h20;
  localparam logic [CharW-1:0] CH_US    = 8'h5F;
  localparam logic [CharW-1:0] CH_E_LO  = 8'h65;
  localparam logic [CharW-1:0] CH_E_UP  = 8'h45;
  localparam logic [CharW-1:0] CH_DOT   = 8'h2E;
  localparam logic [CharW-1:0] CH_SLASH = 8'h2F;
  localparam logic [CharW-1:0] CH_STAR  = 8'h2A;
  localparam logic [CharW-1:0] CH_QUOTE = 8'h22;
  localparam logic [CharW-1:0] CH_COLON = 8'h3A;
  localparam logic [CharW-1:0] CH_SEMI  = 8'h3B;
  localparam logic [CharW-1:0] CH_COMMA = 8'h2C;
  localparam logic [CharW-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CharW-1:0] CH_MINUS = 8'h2D;
  localparam logic [CharW-1:0] CH_LP    = 8'h28;
  localparam logic [CharW-1:0] CH_RP    = 8'h29;
  localparam logic [CharW-1:0] CH_LCB   = 8'h7B;
  localparam logic [CharW-1:0] CH_RCB   = 8'h7D;

  typedef struct packed {
    logic             has_char;
    logic [CharW-1:0] text_char;
    logic             token_done;
    logic [KindW-1:0] token_kind;
    logic [ErrW-1:0]  error_kind;
  } res_t;

  // results of one input byte: count 0..2, slot 0 first
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } bundle_t;

  function automatic logic is_alpha(input logic [CharW-1:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_dig(input logic [CharW-1:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic res_t mk_char(input logic [CharW-1:0] c);
    res_t r;
    r = '0;
    r.has_char  = 1'b1;
    r.text_char = c;
    return r;
  endfunction

  function automatic res_t mk_tok(input logic [KindW-1:0] k);
    res_t r;
    r = '0;
    r.token_done = 1'b1;
    r.token_kind = k;
    return r;
  endfunction

  function automatic res_t mk_err(input logic [ErrW-1:0] e);
    res_t r;
    r = '0;
    r.token_done = 1'b1;
    r.token_kind = K_ERR;
    r.error_kind = e;
    return r;
  endfunction

endpackage

>>> sv/ltl_step.sv
module ltl_step import ltl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [CharW-1:0] ch,
  input  logic             at_end,
  input  logic             digits_as_letters,
  output bundle_t          bundle
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_BSL   = 4'd1;
  localparam logic [3:0] ST_SIGN  = 4'd2;
  localparam logic [3:0] ST_NUM1  = 4'd3;
  localparam logic [3:0] ST_DOT   = 4'd4;
  localparam logic [3:0] ST_NUM2  = 4'd5;
  localparam logic [3:0] ST_NUM3  = 4'd6;
  localparam logic [3:0] ST_NUM4  = 4'd7;
  localparam logic [3:0] ST_ID    = 4'd8;
  localparam logic [3:0] ST_DQ    = 4'd9;
  localparam logic [3:0] ST_DQESC = 4'd10;
  localparam logic [3:0] ST_CM1   = 4'd11;
  localparam logic [3:0] ST_CM2   = 4'd12;
  localparam logic [3:0] ST_CM3   = 4'd13;
  localparam logic [3:0] ST_CM4   = 4'd14;

  logic [3:0] lex_state, lex_state_next;
  logic       mode_latched, mode_latched_next;

  res_t       slot [2];
  logic [1:0] n;
  logic       redo;
  logic       dig;

  always_comb begin
    slot[0]           = '0;
    slot[1]           = '0;
    n                 = 2'd0;
    redo              = 1'b0;
    lex_state_next    = lex_state;
    mode_latched_next = mode_latched;
    dig               = !at_end && is_dig(ch);

    case (lex_state)
      ST_BSL: begin
        lex_state_next = ST_IDLE;
        redo = !(!at_end && ch == CH_NL);
      end
      ST_SIGN: begin
        if (dig) begin
          slot[0] = mk_char(CH_MINUS);
          slot[1] = mk_char(ch);
          n = 2'd2;
          lex_state_next = ST_NUM1;
        end else begin
          slot[0] = mk_tok(K_MINUS); n = 2'd1;
          lex_state_next = ST_IDLE; redo = 1'b1;
        end
      end
      ST_NUM1: begin
        if (dig) begin
          slot[0] = mk_char(ch); n = 2'd1;
        end else if (!at_end && ch == CH_DOT) begin
          slot[0] = mk_char(ch); n = 2'd1;
          lex_state_next = ST_DOT;
        end else begin
          slot[0] = mk_tok(K_INT); n = 2'd1;
          lex_state_next = ST_IDLE; redo = 1'b1;
        end
      end
      ST_DOT: begin
        if (dig) begin
          slot[0] = mk_char(ch); n = 2'd1;
          lex_state_next = ST_NUM2;
        end else begin
          slot[0] = mk_err(E_NO_FRAC); n = 2'd1;
          lex_state_next = ST_IDLE; redo = 1'b1;
        end
      end
      ST_NUM2: begin
        if (dig) begin
          slot[0] = mk_char(ch); n = 2'd1;
        end else if (!at_end && (ch == CH_E_LO || ch == CH_E_UP)) begin
          slot[0] = mk_char(ch); n = 2'd1;
          lex_state_next = ST_NUM3;
        end else begin
          slot[0] = mk_tok(K_FLOAT); n = 2'd1;
          lex_state_next = ST_IDLE; redo = 1'b1;
        end
      end
      ST_NUM3: begin
        if (dig || (!at_end && (ch == CH_PLUS || ch == CH_MINUS))) begin
          slot[0] = mk_char(ch); n = 2'd1;
          lex_state_next = ST_NUM4;
        end else begin
          slot[0] = mk_err(E_NO_EXP); n = 2'd1;
          lex_state_next = ST_IDLE; redo = 1'b1;
        end
      end
      ST_NUM4: begin
        if (dig) begin
          slot[0] = mk_char(ch); n = 2'd1;
        end else begin
          slot[0] = mk_tok(K_FLOAT); n = 2'd1;
          lex_state_next = ST_IDLE; redo = 1'b1;
        end
      end
      ST_ID: begin
        if (!at_end && (is_alpha(ch) || ch == CH_US || is_dig(ch) ||
                        (mode_latched && ch == CH_DOT))) begin
          slot[0] = mk_char(ch); n = 2'd1;
        end else begin
          slot[0] = mk_tok(K_SYM); n = 2'd1;
          lex_state_next = ST_IDLE; redo = 1'b1;
        end
      end
      ST_DQ: begin
        lex_state_next = ST_IDLE;
        if (at_end) begin
          slot[0] = mk_err(E_END_STR); n = 2'd1;
        end else if (ch == CH_QUOTE) begin
          slot[0] = mk_tok(K_SYM); n = 2'd1;
        end else if (ch == CH_NL) begin
          slot[0] = mk_err(E_NL_STR); n = 2'd1;
        end else if (ch == CH_BSL) begin
          lex_state_next = ST_DQESC;
        end else begin
          slot[0] = mk_char(ch); n = 2'd1;
          lex_state_next = ST_DQ;
        end
      end
      ST_DQESC: begin
        lex_state_next = ST_IDLE;
        if (at_end) begin
          slot[0] = mk_err(E_END_STR); n = 2'd1;
        end else if (ch == CH_NL) begin
          slot[0] = mk_char(ch); n = 2'd1;
          lex_state_next = ST_DQ;
        end else begin
          slot[0] = mk_char(CH_BSL);
          slot[1] = mk_char(ch);
          n = 2'd2;
          lex_state_next = ST_DQ;
        end
      end
      ST_CM1: begin
        if (!at_end && ch == CH_SLASH) begin
          lex_state_next = ST_CM2;
        end else if (!at_end && ch == CH_STAR) begin
          lex_state_next = ST_CM3;
        end else begin
          slot[0] = mk_tok(K_DIV); n = 2'd1;
          lex_state_next = ST_IDLE; redo = 1'b1;
        end
      end
      ST_CM2: begin
        if (at_end) begin
          slot[0] = mk_tok(K_END); n = 2'd1;
          lex_state_next = ST_IDLE;
        end else if (ch == CH_NL) begin
          lex_state_next = ST_IDLE;
        end
      end
      ST_CM3: begin
        if (at_end) begin
          slot[0] = mk_err(E_END_CMT); n = 2'd1;
          lex_state_next = ST_IDLE;
        end else if (ch == CH_STAR) begin
          lex_state_next = ST_CM4;
        end
      end
      ST_CM4: begin
        if (at_end) begin
          slot[0] = mk_err(E_END_CMT); n = 2'd1;
          lex_state_next = ST_IDLE;
        end else if (ch == CH_SLASH) begin
          lex_state_next = ST_IDLE;
        end else if (ch != CH_STAR) begin
          lex_state_next = ST_CM3;
        end
      end
      default: begin
        // idle and unused codes
        lex_state_next = ST_IDLE;
        redo = 1'b1;
      end
    endcase

    // token start: byte handled from idle, after any pending token ended
    if (redo) begin
      mode_latched_next = digits_as_letters;
      lex_state_next    = ST_IDLE;
      if (at_end) begin
        slot[n[0]] = mk_tok(K_END); n = n + 2'd1;
      end else if (is_alpha(ch) || ch == CH_US ||
                   (digits_as_letters && (is_dig(ch) || ch == CH_DOT))) begin
        slot[n[0]] = mk_char(ch); n = n + 2'd1;
        lex_state_next = ST_ID;
      end else if (is_dig(ch)) begin
        slot[n[0]] = mk_char(ch); n = n + 2'd1;
        lex_state_next = ST_NUM1;
      end else begin
        case (ch)
          CH_DOT: begin
            slot[n[0]] = mk_char(ch); n = n + 2'd1;
            lex_state_next = ST_DOT;
          end
          CH_SP, CH_TAB: ;
          CH_NL:    begin slot[n[0]] = mk_tok(K_NL);    n = n + 2'd1; end
          CH_QUOTE: lex_state_next = ST_DQ;
          CH_BSL:   lex_state_next = ST_BSL;
          CH_SLASH: lex_state_next = ST_CM1;
          CH_MINUS: lex_state_next = ST_SIGN;
          CH_COLON: begin slot[n[0]] = mk_tok(K_COLON); n = n + 2'd1; end
          CH_SEMI:  begin slot[n[0]] = mk_tok(K_SEMI);  n = n + 2'd1; end
          CH_COMMA: begin slot[n[0]] = mk_tok(K_COMMA); n = n + 2'd1; end
          CH_PLUS:  begin slot[n[0]] = mk_tok(K_PLUS);  n = n + 2'd1; end
          CH_STAR:  begin slot[n[0]] = mk_tok(K_MULT);  n = n + 2'd1; end
          CH_LP:    begin slot[n[0]] = mk_tok(K_LP);    n = n + 2'd1; end
          CH_RP:    begin slot[n[0]] = mk_tok(K_RP);    n = n + 2'd1; end
          CH_LCB:   begin slot[n[0]] = mk_tok(K_LCB);   n = n + 2'd1; end
          CH_RCB:   begin slot[n[0]] = mk_tok(K_RCB);   n = n + 2'd1; end
          default:  begin slot[n[0]] = mk_err(E_BAD_CHAR); n = n + 2'd1; end
        endcase
      end
    end

    bundle.cnt = n;
    bundle.r0  = slot[0];
    bundle.r1  = slot[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_state    <= ST_IDLE;
      mode_latched <= 1'b0;
    end else if (advance) begin
      lex_state    <= lex_state_next;
      mode_latched <= mode_latched_next;
    end
  end

endmodule

>>> sv/ltl_out.sv
module ltl_out import ltl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  bundle_t          bundle,
  output logic             free,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [CharW-1:0] m_tdata,
  output logic             m_tlast,
  output logic [9:0]       m_tuser
);

  `include "liberty_token_lexer_core_macros.svh"

  logic    valid;
  logic    idx;
  logic    two;
  res_t    r0, r1;
  res_t    cur;
  logic    is_last;
  logic    take;

  assign cur      = idx ? r1 : r0;
  assign is_last  = !two || idx;
  assign take     = valid && m_tready;
  assign free     = !valid || (take && is_last);

  assign m_tvalid = valid;
  assign m_tdata  = cur.text_char;
  assign m_tlast  = is_last;
  assign m_tuser  = {cur.error_kind, cur.token_kind, cur.token_done, cur.has_char};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= 1'b0;
    end else if (take) begin
      if (is_last) begin
        valid <= 1'b0;
      end else begin
        idx <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      two <= bundle.cnt == 2'd2;
      r0  <= bundle.r0;
      r1  <= bundle.r1;
    end
  end

  `LTL_ASSERT_IMP(a_load_free, clk, rst, load, free && bundle.cnt != 2'd0,
    "result register loaded while busy")
  `LTL_ASSERT_IMP(a_one_kind, clk, rst, valid, !(cur.has_char && cur.token_done),
    "result carries character and token end")
  `LTL_ASSERT_IMP(a_err_code, clk, rst, valid && cur.token_done,
    (cur.token_kind == K_ERR) == (cur.error_kind != E_NONE),
    "error code does not match token kind")
  `LTL_ASSERT_NXT(a_drain, clk, rst, take && is_last && !load, !valid,
    "result register not emptied after last transfer")

endmodule

>>> sv/liberty_token_lexer_core.sv
// Streaming lexer for cell-library text: one byte (or an end-of-input mark on
// s_tlast) per transfer, results one per transfer on the master side. A byte
// is taken every cycle as long as it yields at most one result and the output
// keeps up; a byte that yields two results (for example a minus sign followed
// by a digit, or an escape inside a string) holds up the next byte that yields
// a result until the second of its results is taken, because the result
// register hands out at most one result per cycle. An accepted byte passes
// through the input register, then the lexer state update and the result
// register. Bytes that yield no result (blanks, comments, opening quotes) pass
// at one per cycle. m_tlast marks the final result of a byte. digits_as_letters
// on s_tuser is sampled whenever a new token starts.
module liberty_token_lexer_core import ltl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [CharW-1:0] s_tdata,   // [7:0] ch
  input  logic             s_tlast,   // at_end
  input  logic             s_tuser,   // [0] digits_as_letters
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [CharW-1:0] m_tdata,   // [7:0] text_char
  output logic             m_tlast,   // last
  output logic [9:0]       m_tuser    // [0] has_char, [1] token_done,
                                      // [6:2] token_kind, [9:7] error_kind
);

  logic             in_valid;
  logic [CharW-1:0] in_ch;
  logic             in_end;
  logic             in_dal;
  bundle_t          bundle;
  logic             free;
  logic             advance;
  logic             load;

  assign advance  = in_valid && (bundle.cnt == 2'd0 || free);
  assign load     = advance && bundle.cnt != 2'd0;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_ch  <= s_tdata;
      in_end <= s_tlast;
      in_dal <= s_tuser;
    end
  end

  ltl_step u_step (
    .clk               (clk),
    .rst               (rst),
    .advance           (advance),
    .ch                (in_ch),
    .at_end            (in_end),
    .digits_as_letters (in_dal),
    .bundle            (bundle)
  );

  ltl_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .bundle   (bundle),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
